FILE: hw/rtl/swlrl_pkg.sv
// ----------------------------------------------------------------------------
// swlrl_pkg
// Types, constants and helpers shared by the sliding-window-log rate limiter.
// ----------------------------------------------------------------------------
package swlrl_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int MAX_STAMPS    = 16;
   localparam int SWEEP_PERIOD  = 256;

   localparam int KEY_W     = 64;
   localparam int TIME_W    = 48;
   localparam int LIMIT_W   = 5;
   localparam int WINDOW_W  = 32;
   localparam int TRACK_W   = 7;
   localparam int CSR_DATA_W = 32;

   localparam int ENTRY_W  = $clog2(TABLE_ENTRIES);
   localparam int HEAD_W   = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
   localparam int CNT_W    = $clog2(MAX_STAMPS + 1);
   localparam int RING_AW  = $clog2(TABLE_ENTRIES * MAX_STAMPS);
   localparam int SWEEP_W  = (SWEEP_PERIOD > 1) ? $clog2(SWEEP_PERIOD) : 1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

   typedef enum logic {
      CSR_REQUEST_LIMIT = 1'b0,
      CSR_WINDOW_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0]  client_key;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic               admitted;
      logic               table_full;
      logic [TRACK_W-1:0] tracked_keys;
   } rsp_type;

   typedef struct packed {
      logic [HEAD_W-1:0] head;
      logic [CNT_W-1:0]  count;
   } meta_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SW_CHECK,
      ST_SW_NEXT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_END,
      ST_META_RD,
      ST_META_LD,
      ST_STAMP_RD,
      ST_STAMP_CHK,
      ST_PRUNE_END,
      ST_APPEND,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic idx_next;
      logic key_rd;
      logic scan_next;
      logic alloc;
      logic set_full;
      logic meta_rd;
      logic meta_ld;
      logic stamp_rd;
      logic stamp_chk;
      logic meta_wr;
      logic free_empty;
      logic append;
   } cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic sweep_go;
      logic entry_valid;
      logic key_hit;
      logic idx_last;
      logic free_found;
      logic stamps_done;
   } status_type;

   function automatic logic [HEAD_W-1:0] ring_pos(input logic [HEAD_W-1:0] head,
                                                   input logic [CNT_W-1:0] offset);
      logic [CNT_W+HEAD_W-1:0] sum;
      sum = (CNT_W+HEAD_W)'(head) + (CNT_W+HEAD_W)'(offset);
      if (sum >= (CNT_W+HEAD_W)'(MAX_STAMPS)) begin
         sum = sum - (CNT_W+HEAD_W)'(MAX_STAMPS);
      end
      return sum[HEAD_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/sliding_window_log_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_log_rate_limiter_unit
// Per-client sliding-window-log rate limiter with a 64-entry key table.
// ----------------------------------------------------------------------------
// Raise start while busy is low to transfer one request; busy stays high until
// the single result, which appears on rsp_data for exactly one cycle with
// rsp_valid and cannot be held off. With request_limit at zero the result
// appears in the cycle right after the transfer. Otherwise the block walks the
// key table one entry at a time (registered key memory read, then compare),
// then prunes the entry's stamp ring one stored stamp at a time (one stamp
// memory read port); every SWEEP_PERIOD limited requests a sweep first prunes
// every valid entry the same way. The configuration port is always ready;
// write it only while idle.
// ----------------------------------------------------------------------------
module sliding_window_log_rate_limiter_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  swlrl_pkg::req_type       req_data,
   output logic                     rsp_valid,
   output swlrl_pkg::rsp_type       rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  swlrl_pkg::csr_index_type csr_index,
   input  logic [swlrl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import swlrl_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   swlrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   swlrl_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/swlrl_ctrl.sv
// ----------------------------------------------------------------------------
// swlrl_ctrl
// Request sequencer: sweep, key scan, allocation, prune and append steps.
// ----------------------------------------------------------------------------
module swlrl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  swlrl_pkg::status_type status,
   output swlrl_pkg::cmd_type    cmd
);
   import swlrl_pkg::*;

   state_type state_ff, state_in;
   logic      sweep_mode_ff, sweep_mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sweep_mode_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_mode_ff <= sweep_mode_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_mode_in = sweep_mode_ff;
      cmd           = '0;
      busy          = (state_ff != ST_IDLE);
      rsp_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.limit_zero ? ST_RESP : ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.sweep_go) begin
               sweep_mode_in = 1'b1;
               state_in      = ST_SW_CHECK;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SW_CHECK: begin
            state_in = status.entry_valid ? ST_META_RD : ST_SW_NEXT;
         end
         ST_SW_NEXT: begin
            cmd.idx_next = 1'b1;
            if (status.idx_last) begin
               sweep_mode_in = 1'b0;
               state_in      = ST_SCAN_RD;
            end else begin
               state_in = ST_SW_CHECK;
            end
         end
         ST_SCAN_RD: begin
            cmd.key_rd = 1'b1;
            state_in   = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (status.key_hit) begin
               state_in = ST_META_RD;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = status.idx_last ? ST_SCAN_END : ST_SCAN_RD;
            end
         end
         ST_SCAN_END: begin
            if (status.free_found) begin
               cmd.alloc = 1'b1;
               state_in  = ST_STAMP_RD;
            end else begin
               cmd.set_full = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_META_RD: begin
            cmd.meta_rd = 1'b1;
            state_in    = ST_META_LD;
         end
         ST_META_LD: begin
            cmd.meta_ld = 1'b1;
            state_in    = ST_STAMP_RD;
         end
         ST_STAMP_RD: begin
            if (status.stamps_done) begin
               state_in = ST_PRUNE_END;
            end else begin
               cmd.stamp_rd = 1'b1;
               state_in     = ST_STAMP_CHK;
            end
         end
         ST_STAMP_CHK: begin
            cmd.stamp_chk = 1'b1;
            state_in      = ST_STAMP_RD;
         end
         ST_PRUNE_END: begin
            cmd.meta_wr = 1'b1;
            if (sweep_mode_ff) begin
               cmd.free_empty = 1'b1;
               state_in       = ST_SW_NEXT;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/swlrl_dp.sv
// ----------------------------------------------------------------------------
// swlrl_dp
// Key table, stamp rings, per-entry ring metadata and configuration registers.
// ----------------------------------------------------------------------------
module swlrl_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  swlrl_pkg::req_type     req_data,
   input  logic                   csr_valid,
   input  swlrl_pkg::csr_index_type csr_index,
   input  logic [swlrl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  swlrl_pkg::cmd_type     cmd,
   output swlrl_pkg::status_type  status,
   output swlrl_pkg::rsp_type     rsp_data
);
   import swlrl_pkg::*;

   logic [KEY_W-1:0]   key_mem   [TABLE_ENTRIES];
   meta_type           meta_mem  [TABLE_ENTRIES];
   logic [TIME_W-1:0]  stamp_mem [TABLE_ENTRIES*MAX_STAMPS];

   logic [LIMIT_W-1:0]       limit_ff;
   logic [WINDOW_W-1:0]      window_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TRACK_W-1:0]       tracked_ff;
   logic [SWEEP_W-1:0]       sweep_ff;
   logic                     sweep_go_ff;
   logic [KEY_W-1:0]         key_ff;
   logic [TIME_W-1:0]        now_ff;
   logic [ENTRY_W-1:0]       entry_ff;
   logic                     free_vld_ff;
   logic [ENTRY_W-1:0]       free_idx_ff;
   logic [HEAD_W-1:0]        head_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         idx_ff;
   logic [CNT_W-1:0]         kept_ff;
   logic                     admit_ff;
   logic                     full_ff;
   logic [KEY_W-1:0]         key_q_ff;
   meta_type                 meta_q_ff;
   logic [TIME_W-1:0]        stamp_q_ff;

   logic [RING_AW-1:0] ring_base;
   logic [RING_AW-1:0] wr_addr;
   logic [RING_AW-1:0] rd_addr;
   logic               fresh;
   logic               can_admit;
   logic               sweep_due;

   assign ring_base = RING_AW'(entry_ff) * RING_AW'(MAX_STAMPS);
   assign wr_addr   = ring_base + RING_AW'(ring_pos(head_ff, kept_ff));
   assign rd_addr   = ring_base + RING_AW'(ring_pos(head_ff, idx_ff));
   assign fresh     = ({1'b0, stamp_q_ff} + (TIME_W+1)'(window_ff)) >= {1'b0, now_ff};
   assign can_admit = (32'(kept_ff) < 32'(limit_ff)) && (32'(kept_ff) < 32'(MAX_STAMPS));
   assign sweep_due = (sweep_ff == SWEEP_W'(SWEEP_PERIOD - 1));

   assign status.limit_zero  = (limit_ff == '0);
   assign status.sweep_go    = sweep_go_ff;
   assign status.entry_valid = valid_ff[entry_ff];
   assign status.key_hit     = valid_ff[entry_ff] && (key_q_ff == key_ff);
   assign status.idx_last    = (entry_ff == ENTRY_W'(TABLE_ENTRIES - 1));
   assign status.free_found  = free_vld_ff;
   assign status.stamps_done = (idx_ff == cnt_ff);

   assign rsp_data.admitted     = admit_ff;
   assign rsp_data.table_full   = full_ff;
   assign rsp_data.tracked_keys = tracked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= '0;
         window_ff   <= WINDOW_RESET;
         valid_ff    <= '0;
         tracked_ff  <= '0;
         sweep_ff    <= '0;
         sweep_go_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_REQUEST_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
               CSR_WINDOW_LENGTH: window_ff <= csr_wdata[WINDOW_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load && (limit_ff != '0)) begin
            sweep_ff    <= sweep_due ? '0 : sweep_ff + 1'b1;
            sweep_go_ff <= sweep_due;
         end
         if (cmd.alloc) begin
            valid_ff[free_idx_ff] <= 1'b1;
            tracked_ff            <= tracked_ff + 1'b1;
         end
         if (cmd.free_empty && (kept_ff == '0)) begin
            valid_ff[entry_ff] <= 1'b0;
            tracked_ff         <= tracked_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff      <= req_data.client_key;
         now_ff      <= req_data.now_time;
         entry_ff    <= '0;
         free_vld_ff <= 1'b0;
         admit_ff    <= (limit_ff == '0);
         full_ff     <= 1'b0;
      end
      if (cmd.idx_next) begin
         entry_ff <= status.idx_last ? '0 : entry_ff + 1'b1;
      end
      if (cmd.scan_next) begin
         if (!valid_ff[entry_ff] && !free_vld_ff) begin
            free_vld_ff <= 1'b1;
            free_idx_ff <= entry_ff;
         end
         entry_ff <= status.idx_last ? '0 : entry_ff + 1'b1;
      end
      if (cmd.alloc) begin
         entry_ff <= free_idx_ff;
         head_ff  <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         kept_ff  <= '0;
      end
      if (cmd.set_full) begin
         full_ff <= 1'b1;
      end
      if (cmd.meta_ld) begin
         head_ff <= meta_q_ff.head;
         cnt_ff  <= meta_q_ff.count;
         idx_ff  <= '0;
         kept_ff <= '0;
      end
      if (cmd.stamp_chk) begin
         idx_ff <= idx_ff + 1'b1;
         if (fresh) begin
            kept_ff <= kept_ff + 1'b1;
         end
      end
      if (cmd.append && can_admit) begin
         admit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         key_mem[free_idx_ff] <= key_ff;
      end
      if (cmd.key_rd) begin
         key_q_ff <= key_mem[entry_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.meta_wr) begin
         meta_mem[entry_ff] <= '{head: head_ff, count: kept_ff};
      end else if (cmd.append && can_admit) begin
         meta_mem[entry_ff] <= '{head: head_ff, count: kept_ff + 1'b1};
      end
      if (cmd.meta_rd) begin
         meta_q_ff <= meta_mem[entry_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stamp_chk && fresh) begin
         stamp_mem[wr_addr] <= stamp_q_ff;
      end else if (cmd.append && can_admit) begin
         stamp_mem[wr_addr] <= now_ff;
      end
      if (cmd.stamp_rd) begin
         stamp_q_ff <= stamp_mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/swlrl_checker.sv
// ----------------------------------------------------------------------------
// swlrl_checker
// Port-level checks on request and result sequencing and full-table results.
// ----------------------------------------------------------------------------
module swlrl_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input swlrl_pkg::rsp_type rsp_data
);
   import swlrl_pkg::*;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a request");

   a_transfer_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer did not raise busy");

   a_full_denies: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.table_full) |-> !rsp_data.admitted)
      else $error("full table admitted a request");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.table_full) |-> (rsp_data.tracked_keys == TRACK_W'(TABLE_ENTRIES)))
      else $error("table full with free entries");

endmodule

bind sliding_window_log_rate_limiter_unit swlrl_checker u_swlrl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
